### src/tlnf_pkg.sv
// Shared types, constants and helper functions for the text line number filter.
package tlnf_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int LINE_W        = 20;
  localparam int CNT_W         = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam int QDEPTH        = 4;
  localparam int QAW           = 2;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

  localparam logic [7:0] ASCII_TAB    = 8'h09;
  localparam logic [7:0] ASCII_LF     = 8'h0A;
  localparam logic [7:0] ASCII_SPACE  = 8'h20;
  localparam logic [7:0] ASCII_DOLLAR = 8'h24;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_CARET  = 8'h5E;
  localparam logic [7:0] ASCII_I      = 8'h49;
  localparam logic [7:0] CTRL_MAX     = 8'd31;
  localparam logic [7:0] DEL_BYTE     = 8'd127;
  localparam logic [7:0] CARET_OFFSET = 8'd64;
  localparam logic [1:0] RUN_SAT      = 2'd3;

  typedef logic [NUMBER_DIGITS-1:0][3:0] bcd_t;

  localparam bcd_t BCD_ONE = bcd_t'(1);

  typedef struct packed {
    logic       num_en;
    bcd_t       digits;
    logic       dollar;
    logic       caret;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [LINE_W-1:0] line_limit();
    logic [63:0] lim;
    logic        sat;
    lim = 64'd1;
    sat = 1'b0;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      lim = lim * 64'd10;
      if (lim > 64'((1 << LINE_W) - 1)) sat = 1'b1;
    end
    if (sat) return {LINE_W{1'b1}};
    return LINE_W'(lim - 64'd1);
  endfunction

  localparam logic [LINE_W-1:0] LINE_LIMIT = line_limit();

  function automatic bcd_t bcd_inc(input bcd_t d);
    bcd_t r;
    logic carry;
    r = d;
    carry = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (r[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i] = r[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage

### src/text_line_number_filter_unit.sv
// Top level of the text line number filter: front end, command queue and byte expander.
//
//   channel  direction  handshake             beat
//   input    in         push / full           in_byte, in_start_of_file
//   result   out        empty / pop           out_byte, out_last
//   config   in         cfg_we (no stall)     cfg_idx, cfg_wdata
//
// Each input byte is classified in the cycle it is accepted and becomes 0 to 9 result
// beats (a squeezed blank line yields none), one per cycle from the expander while pop
// does not stall, so the sustained rate is one input byte per cycle when each byte yields
// one beat. The first result beat is written into the command queue and then into the
// result register before it is on the result ports. Reset is synchronous (rst_n low).
// full rises when the 4-entry command queue fills; a stalled pop holds the result register.
module text_line_number_filter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tlnf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic                           cfg_wdata,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     in_byte,
  input  logic                           in_start_of_file,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_byte,
  output logic                           out_last
);

  tlnf_pkg::cmd_t cmd_in, cmd_head;
  logic           cmd_push, head_pop, q_empty, accept;

  assign accept = push && !full;

  tlnf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (accept),
    .in_byte   (in_byte),
    .in_sof    (in_start_of_file),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  tlnf_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_cmd  (cmd_in),
    .q_full  (full),
    .rd_en   (head_pop),
    .rd_cmd  (cmd_head),
    .q_empty (q_empty)
  );

  tlnf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (cmd_head),
    .head_empty (q_empty),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule

### src/tlnf_front.sv
// Front end: configuration registers, line state tracking and command classification.
module tlnf_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tlnf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic                           cfg_wdata,
  input  logic                           in_valid,
  input  logic [7:0]                     in_byte,
  input  logic                           in_sof,
  output logic                           cmd_push,
  output tlnf_pkg::cmd_t                 cmd
);

  logic number_nonblank_r, number_all_r, show_ends_r;
  logic squeeze_blank_r, show_tabs_r, show_nonprinting_r;

  logic [tlnf_pkg::LINE_W-1:0] line_bin_r, line_bin_nxt, base_bin;
  tlnf_pkg::bcd_t              line_bcd_r, line_bcd_nxt, base_bcd;
  logic                        at_ls_r, at_ls_nxt, base_at;
  logic [1:0]                  run_r, run_nxt, base_run;

  logic nl, tab, drop, num_mode, do_num;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_nonblank_r  <= 1'b0;
      number_all_r       <= 1'b0;
      show_ends_r        <= 1'b0;
      squeeze_blank_r    <= 1'b0;
      show_tabs_r        <= 1'b0;
      show_nonprinting_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tlnf_pkg::REG_NUMBER_NONBLANK:  number_nonblank_r  <= cfg_wdata;
        tlnf_pkg::REG_NUMBER_ALL:       number_all_r       <= cfg_wdata;
        tlnf_pkg::REG_SHOW_ENDS:        show_ends_r        <= cfg_wdata;
        tlnf_pkg::REG_SQUEEZE_BLANK:    squeeze_blank_r    <= cfg_wdata;
        tlnf_pkg::REG_SHOW_TABS:        show_tabs_r        <= cfg_wdata;
        tlnf_pkg::REG_SHOW_NONPRINTING: show_nonprinting_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    nl  = (in_byte == tlnf_pkg::ASCII_LF);
    tab = (in_byte == tlnf_pkg::ASCII_TAB);

    base_bin = in_sof ? tlnf_pkg::LINE_W'(1) : line_bin_r;
    base_bcd = in_sof ? tlnf_pkg::BCD_ONE : line_bcd_r;
    base_at  = in_sof | at_ls_r;
    base_run = in_sof ? 2'd1 : run_r;

    run_nxt = base_run;
    if (squeeze_blank_r) begin
      if (nl) run_nxt = (base_run < tlnf_pkg::RUN_SAT) ? base_run + 2'd1 : tlnf_pkg::RUN_SAT;
      else    run_nxt = 2'd0;
    end
    drop = squeeze_blank_r && (run_nxt == tlnf_pkg::RUN_SAT);

    num_mode = number_nonblank_r | number_all_r;
    do_num   = !drop && num_mode && base_at && (!nl || !number_nonblank_r);

    at_ls_nxt = base_at;
    if (!drop && num_mode) begin
      if (nl)          at_ls_nxt = 1'b1;
      else if (do_num) at_ls_nxt = 1'b0;
    end

    line_bin_nxt = base_bin;
    line_bcd_nxt = base_bcd;
    if (do_num && (base_bin < tlnf_pkg::LINE_LIMIT)) begin
      line_bin_nxt = base_bin + tlnf_pkg::LINE_W'(1);
      line_bcd_nxt = tlnf_pkg::bcd_inc(base_bcd);
    end

    cmd.num_en = do_num;
    cmd.digits = base_bcd;
    cmd.dollar = show_ends_r && nl;
    cmd.caret  = 1'b0;
    cmd.data   = in_byte;
    if (show_tabs_r && tab) begin
      cmd.caret = 1'b1;
      cmd.data  = tlnf_pkg::ASCII_I;
    end else if (show_nonprinting_r && !nl && !tab) begin
      if (in_byte <= tlnf_pkg::CTRL_MAX) begin
        cmd.caret = 1'b1;
        cmd.data  = in_byte + tlnf_pkg::CARET_OFFSET;
      end else if (in_byte == tlnf_pkg::DEL_BYTE) begin
        cmd.caret = 1'b1;
        cmd.data  = in_byte - tlnf_pkg::CARET_OFFSET;
      end
    end

    cmd_push = in_valid && !drop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bin_r <= tlnf_pkg::LINE_W'(1);
      line_bcd_r <= tlnf_pkg::BCD_ONE;
      at_ls_r    <= 1'b1;
      run_r      <= 2'd1;
    end else if (in_valid) begin
      line_bin_r <= line_bin_nxt;
      line_bcd_r <= line_bcd_nxt;
      at_ls_r    <= at_ls_nxt;
      run_r      <= run_nxt;
    end
  end

endmodule

### src/tlnf_cmdq.sv
// Short command queue between the front end and the byte expander.
module tlnf_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  tlnf_pkg::cmd_t wr_cmd,
  output logic           q_full,
  input  logic           rd_en,
  output tlnf_pkg::cmd_t rd_cmd,
  output logic           q_empty
);

  tlnf_pkg::cmd_t                mem [tlnf_pkg::QDEPTH];
  logic [tlnf_pkg::QAW-1:0]      wp_r, rp_r;
  logic [tlnf_pkg::QAW:0]        count_r, count_nxt;
  logic                          do_wr, do_rd;

  assign q_full  = (count_r == (tlnf_pkg::QAW+1)'(tlnf_pkg::QDEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_cmd  = mem[rp_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd)      count_nxt = count_r + (tlnf_pkg::QAW+1)'(1);
    else if (do_rd && !do_wr) count_nxt = count_r - (tlnf_pkg::QAW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + tlnf_pkg::QAW'(1);
      if (do_rd) rp_r <= rp_r + tlnf_pkg::QAW'(1);
      count_r <= count_nxt;
    end
  end

endmodule

### src/tlnf_back.sv
// Back end: expand one command into output register bytes, one beat per cycle unless stalled.
module tlnf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tlnf_pkg::cmd_t head,
  input  logic           head_empty,
  output logic           head_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic           out_last
);

  localparam logic [2:0] PH_NUM  = 3'd0;
  localparam logic [2:0] PH_TAB  = 3'd1;
  localparam logic [2:0] PH_DOL  = 3'd2;
  localparam logic [2:0] PH_CAR  = 3'd3;
  localparam logic [2:0] PH_BYTE = 3'd4;

  logic                       busy_r;
  logic [2:0]                 phase_r, phase, phase_nxt, start_ph, after_tab;
  logic [tlnf_pkg::CNT_W-1:0] cnt_r, cnt, cnt_nxt;
  logic [7:0]                 out_byte_r, byte_cur;
  logic                       out_last_r, out_valid_r, load;
  logic [tlnf_pkg::NUMBER_DIGITS-1:0] lz;
  logic [3:0]                 dig;

  assign empty    = !out_valid_r;
  assign out_byte = out_byte_r;
  assign out_last = out_last_r;
  assign load     = !head_empty && (!out_valid_r || pop);

  always_comb begin
    after_tab = head.dollar ? PH_DOL : (head.caret ? PH_CAR : PH_BYTE);
    start_ph  = head.num_en ? PH_NUM : after_tab;
    phase     = busy_r ? phase_r : start_ph;
    cnt       = busy_r ? cnt_r : '0;

    lz[0] = (head.digits[tlnf_pkg::NUMBER_DIGITS-1] == 4'd0);
    for (int k = 1; k < tlnf_pkg::NUMBER_DIGITS; k++) begin
      lz[k] = lz[k-1] && (head.digits[tlnf_pkg::NUMBER_DIGITS-1-k] == 4'd0);
    end
    dig = head.digits[tlnf_pkg::CNT_W'(tlnf_pkg::NUMBER_DIGITS-1) - cnt];

    phase_nxt = phase;
    cnt_nxt   = cnt;
    byte_cur  = head.data;
    unique case (phase)
      PH_NUM: begin
        if (lz[cnt] && (cnt != tlnf_pkg::CNT_W'(tlnf_pkg::NUMBER_DIGITS-1)))
          byte_cur = tlnf_pkg::ASCII_SPACE;
        else
          byte_cur = tlnf_pkg::ASCII_ZERO + {4'd0, dig};
        if (cnt == tlnf_pkg::CNT_W'(tlnf_pkg::NUMBER_DIGITS-1)) begin
          phase_nxt = PH_TAB;
        end else begin
          cnt_nxt = cnt + tlnf_pkg::CNT_W'(1);
        end
      end
      PH_TAB: begin
        byte_cur  = tlnf_pkg::ASCII_TAB;
        phase_nxt = after_tab;
      end
      PH_DOL: begin
        byte_cur  = tlnf_pkg::ASCII_DOLLAR;
        phase_nxt = head.caret ? PH_CAR : PH_BYTE;
      end
      PH_CAR: begin
        byte_cur  = tlnf_pkg::ASCII_CARET;
        phase_nxt = PH_BYTE;
      end
      default: begin
        byte_cur  = head.data;
        phase_nxt = PH_BYTE;
      end
    endcase

    head_pop = load && (phase == PH_BYTE);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_cur;
      out_last_r <= (phase == PH_BYTE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      phase_r     <= PH_NUM;
      cnt_r       <= '0;
    end else begin
      if (load)     out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;
      if (load) begin
        busy_r  <= (phase != PH_BYTE);
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

endmodule

### test/tb_top.sv
// Self-checking testbench for the text line number filter: queue handshakes, mode sweeps and predictor.
`timescale 1ns / 100ps

module tb_top;
  import tlnf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PRESSURE_HOLD = 120;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{
    REG_NUMBER_NONBLANK, REG_NUMBER_ALL, REG_SHOW_ENDS,
    REG_SQUEEZE_BLANK, REG_SHOW_TABS, REG_SHOW_NONPRINTING
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  class format_board;
    bit              num_nonblank, num_all, ends_on, squeeze_on, tabs_on, nonprint_on;
    logic [LINE_W-1:0] line_no;
    bit              line_start;
    logic [1:0]      nl_run;
    beat_t           pending_beats[$];
    int              mismatches;
    int              beats_seen;
    int              bytes_taken;

    function new();
      line_no = 1;
      line_start = 1;
      nl_run = 1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic v);
      case (idx)
        REG_NUMBER_NONBLANK:  num_nonblank = v;
        REG_NUMBER_ALL:       num_all = v;
        REG_SHOW_ENDS:        ends_on = v;
        REG_SQUEEZE_BLANK:    squeeze_on = v;
        REG_SHOW_TABS:        tabs_on = v;
        REG_SHOW_NONPRINTING: nonprint_on = v;
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] ch, logic sof);
      logic [7:0]  outq[$];
      int unsigned v;
      int unsigned dig[NUMBER_DIGITS];
      bit          lead;
      bit          nl;
      bit          tab;
      beat_t       bt;
      nl = (ch == ASCII_LF);
      tab = (ch == ASCII_TAB);
      bytes_taken++;
      if (sof) begin
        line_no = 1;
        line_start = 1;
        nl_run = 1;
      end
      if (squeeze_on) begin
        if (nl) nl_run = (nl_run < RUN_SAT) ? nl_run + 2'd1 : RUN_SAT;
        else nl_run = 0;
        if (nl_run >= RUN_SAT) return;
      end
      if (num_nonblank || num_all) begin
        if (line_start && (!nl || !num_nonblank)) begin
          v = line_no;
          for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            dig[i] = v % 10;
            v = v / 10;
          end
          lead = 1;
          for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (lead && dig[i] == 0 && i != NUMBER_DIGITS - 1) begin
              outq.push_back(ASCII_SPACE);
            end else begin
              lead = 0;
              outq.push_back(ASCII_ZERO + 8'(dig[i]));
            end
          end
          outq.push_back(ASCII_TAB);
          if (line_no < LINE_LIMIT) line_no = line_no + 1'b1;
          line_start = 0;
        end
        if (nl) line_start = 1;
      end
      if (ends_on && nl) outq.push_back(ASCII_DOLLAR);
      if (tabs_on && tab) begin
        outq.push_back(ASCII_CARET);
        outq.push_back(ASCII_I);
      end else if (nonprint_on && !nl && !tab) begin
        if (ch <= CTRL_MAX) begin
          outq.push_back(ASCII_CARET);
          outq.push_back(ch + CARET_OFFSET);
        end else if (ch == DEL_BYTE) begin
          outq.push_back(ASCII_CARET);
          outq.push_back(ch - CARET_OFFSET);
        end else begin
          outq.push_back(ch);
        end
      end else begin
        outq.push_back(ch);
      end
      foreach (outq[i]) begin
        bt.data = outq[i];
        bt.last = (i == outq.size() - 1);
        pending_beats.push_back(bt);
      end
    endfunction

    function void match_beat(logic [7:0] data, logic last);
      beat_t exp_beat;
      beats_seen++;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected beat: out_byte=%02h out_last=%0b", data, last);
        return;
      end
      exp_beat = pending_beats.pop_front();
      if (data !== exp_beat.data || last !== exp_beat.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("beat %0d mismatch: expected byte=%02h last=%0b, got byte=%02h last=%0b",
                   beats_seen, exp_beat.data, exp_beat.last, data, last);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wdata;
  logic                 push;
  logic                 full;
  logic [7:0]           in_byte;
  logic                 in_start_of_file;
  logic                 empty;
  logic                 pop;
  logic [7:0]           out_byte;
  logic                 out_last;

  format_board board = new();
  bit          idle_on;
  int          hold_request;
  int          cycle_count;
  int          settings_used;

  text_line_number_filter_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .push             (push),
    .full             (full),
    .in_byte          (in_byte),
    .in_start_of_file (in_start_of_file),
    .empty            (empty),
    .pop              (pop),
    .out_byte         (out_byte),
    .out_last         (out_last)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("text_line_number_filter_unit verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'($urandom_range(32, 126));
    if (r < 60) return ASCII_LF;
    if (r < 68) return ASCII_TAB;
    if (r < 78) return 8'($urandom_range(0, 31));
    if (r < 82) return DEL_BYTE;
    if (r < 92) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  // result side: pop with random stalls, plus a long hold when requested
  initial begin
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) board.match_beat(out_byte, out_last);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic sof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= data;
    in_start_of_file <= sof;
    @(posedge clk);
    while (full) @(posedge clk);
    board.take_byte(data, sof);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (board.pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modes(input logic [5:0] modes);
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= REG_ORDER[i];
      cfg_wdata <= modes[i];
      @(posedge clk);
      board.set_reg(REG_ORDER[i], modes[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic write_spare(input logic [CFG_IDX_W-1:0] idx);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= 1'b1;
    @(posedge clk);
    board.set_reg(idx, 1'b1);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_text(input int count);
    int sent;
    int run_len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 8) begin
        run_len = $urandom_range(2, 5);
        for (int k = 0; k < run_len; k++) send_byte(ASCII_LF, 1'b0);
        sent += run_len;
      end else begin
        send_byte(pick_text_byte(), $urandom_range(0, 99) < 2);
        sent++;
      end
    end
  endtask

  initial begin
    logic [5:0] mode_plan [8];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = 1'b0;
    push = 1'b0;
    in_byte = 8'h00;
    in_start_of_file = 1'b0;
    idle_on = 1'b1;
    hold_request = 0;
    cycle_count = 0;
    settings_used = 0;
    mode_plan = '{6'b000000, 6'b111111, 6'b000110, 6'b001001,
                  6'b001000, 6'b110000, 6'b000011, 6'($urandom_range(0, 63))};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: plain pass-through
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(DEL_BYTE, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(ASCII_TAB, 1'b0);
    send_byte(ASCII_LF, 1'b0);
    drain();

    write_spare(REG_SPARE_LO);
    write_spare(REG_SPARE_HI);
    write_modes(6'b111111);
    send_byte("A", 1'b1);
    send_byte(ASCII_TAB, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(CTRL_MAX, 1'b0);
    send_byte(DEL_BYTE, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(ASCII_LF, 1'b0);
    send_byte(ASCII_LF, 1'b0);
    send_byte(ASCII_LF, 1'b0);
    send_byte(ASCII_LF, 1'b0);
    send_byte("B", 1'b0);
    send_byte(ASCII_LF, 1'b0);
    drain();

    write_modes(6'b000110);
    send_byte(ASCII_LF, 1'b1);
    send_byte(ASCII_LF, 1'b0);
    send_byte("x", 1'b0);
    send_byte(ASCII_LF, 1'b0);
    drain();

    foreach (mode_plan[p]) begin
      write_modes(mode_plan[p]);
      idle_on = (p != 2);
      if (p == 1) hold_request = PRESSURE_HOLD;
      send_text(50);
      drain();
    end

    $display("sent %0d input bytes, checked %0d output beats across %0d mode settings",
             board.bytes_taken, board.beats_seen, settings_used);
    $display("modes swept: numbering, squeeze, line ends, tabs, caret notation; long hold");
    if (board.mismatches == 0 && board.pending_beats.size() == 0) begin
      $display("text_line_number_filter_unit verification clean");
    end else begin
      $display("text_line_number_filter_unit verification failed");
    end
    $finish;
  end

endmodule

### text_line_number_filter_unit.f
src/tlnf_pkg.sv
src/tlnf_front.sv
src/tlnf_cmdq.sv
src/tlnf_back.sv
src/text_line_number_filter_unit.sv
test/tb_top.sv
